// ----- design/tlrb_pkg.sv -----
// ----------------------------------------------------------------------------
// tlrb_pkg
// Shared types, codes and character constants for the timestamped log ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tlrb_pkg;

    typedef enum logic [1:0] {
        KIND_LOG  = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Write slot of the logged byte itself, after the eleven stamp characters
    localparam logic [3:0] SLOT_BYTE = 4'd11;

    typedef struct packed {
        logic [3:0] h1;
        logic [3:0] h0;
        logic [3:0] m1;
        logic [3:0] m0;
        logic [3:0] s1;
        logic [3:0] s0;
    } stamp_digits_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        digit_char = CHAR_ZERO | {4'h0, d};
    endfunction

    // Character for one write slot of a stamped line: "[HH:MM:SS] " then the byte
    function automatic logic [7:0] slot_char(input logic [3:0] slot,
                                             input stamp_digits_t dg,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = data;
        unique case (slot)
            4'd0:    c = CHAR_OPEN;
            4'd1:    c = digit_char(dg.h1);
            4'd2:    c = digit_char(dg.h0);
            4'd3:    c = CHAR_COLON;
            4'd4:    c = digit_char(dg.m1);
            4'd5:    c = digit_char(dg.m0);
            4'd6:    c = CHAR_COLON;
            4'd7:    c = digit_char(dg.s1);
            4'd8:    c = digit_char(dg.s0);
            4'd9:    c = CHAR_CLOSE;
            4'd10:   c = CHAR_SPACE;
            default: c = data;
        endcase
        slot_char = c;
    endfunction

endpackage

`default_nettype wire

// ----- design/timestamped_log_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// timestamped_log_ring_buffer
// Byte log ring with line stamps, newline count, tail query and byte read.
// ----------------------------------------------------------------------------
// From accept to done: a dropped carriage return or unused kind answers from
// idle, an unstamped byte is one ring write, a stamped byte waits on the digit
// unit and then writes the eleven stamp characters and the byte, a read is one
// ring read, and a tail query scans at most RING_DEPTH bytes, stopping early at
// a zero byte. One transaction at a time: busy holds off start. Reset clears
// head, wrap flag, line state and count; ring bytes stay undefined until
// written, so no clearing pass runs after reset.
`default_nettype none

module timestamped_log_ring_buffer #(
    parameter int RING_DEPTH = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic [22:0] uptime_seconds,
    input  wire logic [13:0] max_bytes,
    input  wire logic [12:0] position,
    output logic             done,
    output logic [31:0]      line_count,
    output logic [12:0]      tail_start,
    output logic [13:0]      tail_length,
    output logic [7:0]       read_byte
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > 14) ? CW : 14;
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_STAMP     = 9'b000000010,
        ST_PUT       = 9'b000000100,
        ST_RD_ADDR   = 9'b000001000,
        ST_RD_DATA   = 9'b000010000,
        ST_Q_SETUP   = 9'b000100000,
        ST_SCAN_ADDR = 9'b001000000,
        ST_SCAN_DATA = 9'b010000000,
        ST_FINISH    = 9'b100000000
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] head_reg;
    logic          wrapped_reg;
    logic          line_start_reg;
    logic [31:0]   nl_total_reg;
    logic [3:0]    slot_reg;
    logic [7:0]    byte_reg;
    logic [13:0]   limit_reg;
    logic [AW-1:0] pos_reg;
    logic [CW-1:0] want_reg;
    logic [AW-1:0] qstart_reg;
    logic          clipped_reg;
    logic [AW-1:0] scan_addr_reg;
    logic [CW-1:0] scan_i_reg;
    logic [CW-1:0] zpos_reg;
    logic          nl_found_reg;
    logic [CW-1:0] nl_pos_reg;
    logic          done_reg;
    logic [31:0]   line_count_reg;
    logic [12:0]   tail_start_reg;
    logic [13:0]   tail_length_reg;
    logic [7:0]    read_byte_reg;

    logic          accept;
    logic          stamp_start;
    logic          stamp_done;
    tlrb_pkg::stamp_digits_t stamp_digits;

    logic          wr_en;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] scan_inc;
    logic [LW-1:0] lim_ext;
    logic [CW-1:0] lim;
    logic [CW-1:0] avail;
    logic [CW-1:0] want;
    logic [SW-1:0] start_sum;
    logic [AW-1:0] qstart;
    logic [CW-1:0] nl_next_pos;
    logic [CW-1:0] off;
    logic [SW-1:0] tstart_sum;
    logic [AW-1:0] tstart;

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign stamp_start = accept && (kind == tlrb_pkg::KIND_LOG)
                         && (data_byte != tlrb_pkg::CHAR_CR)
                         && (data_byte != tlrb_pkg::CHAR_LF) && line_start_reg;

    always_comb
    begin
        head_inc = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
        scan_inc = (scan_addr_reg == LAST_ADDR) ? '0 : scan_addr_reg + 1'b1;

        // Tail window from the limit, clamped to the ring and to what is held
        lim_ext = LW'(limit_reg);
        lim     = (lim_ext > LW'(RING_DEPTH)) ? CW'(RING_DEPTH) : CW'(lim_ext);
        avail   = wrapped_reg ? CW'(RING_DEPTH) : CW'(head_reg);
        want    = (lim < avail) ? lim : avail;
        start_sum = SW'(head_reg) + SW'(RING_DEPTH) - SW'(want);
        qstart  = (start_sum >= SW'(RING_DEPTH)) ? AW'(start_sum - SW'(RING_DEPTH))
                                                 : AW'(start_sum);

        // Skip the partial first line of a clipped window only when a byte follows its newline
        nl_next_pos = nl_pos_reg + 1'b1;
        off = (clipped_reg && nl_found_reg && (nl_next_pos < zpos_reg))
              ? nl_next_pos : '0;
        tstart_sum = SW'(qstart_reg) + SW'(off);
        tstart  = (tstart_sum >= SW'(RING_DEPTH)) ? AW'(tstart_sum - SW'(RING_DEPTH))
                                                  : AW'(tstart_sum);
    end

    always_comb
    begin
        wr_en   = (state_reg == ST_PUT);
        wr_data = tlrb_pkg::slot_char(slot_reg, stamp_digits, byte_reg);
        rd_en   = (state_reg == ST_RD_ADDR)
                  || ((state_reg == ST_SCAN_ADDR) && (scan_i_reg != want_reg));
        rd_addr = (state_reg == ST_RD_ADDR) ? pos_reg : scan_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            wrapped_reg     <= 1'b0;
            line_start_reg  <= 1'b1;
            nl_total_reg    <= '0;
            done_reg        <= 1'b0;
            line_count_reg  <= '0;
            tail_start_reg  <= '0;
            tail_length_reg <= '0;
            read_byte_reg   <= '0;
            slot_reg        <= '0;
            byte_reg        <= '0;
            limit_reg       <= '0;
            pos_reg         <= '0;
            want_reg        <= '0;
            qstart_reg      <= '0;
            clipped_reg     <= 1'b0;
            scan_addr_reg   <= '0;
            scan_i_reg      <= '0;
            zpos_reg        <= '0;
            nl_found_reg    <= 1'b0;
            nl_pos_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        byte_reg  <= data_byte;
                        limit_reg <= max_bytes;
                        pos_reg   <= AW'(position);
                        unique case (tlrb_pkg::kind_t'(kind))
                            tlrb_pkg::KIND_LOG:
                            begin
                                if (data_byte == tlrb_pkg::CHAR_CR)
                                begin
                                    // drop: report the count only
                                    done_reg        <= 1'b1;
                                    line_count_reg  <= nl_total_reg;
                                    tail_start_reg  <= '0;
                                    tail_length_reg <= '0;
                                    read_byte_reg   <= '0;
                                end
                                else if (stamp_start)
                                begin
                                    slot_reg  <= '0;
                                    state_reg <= ST_STAMP;
                                end
                                else
                                begin
                                    slot_reg  <= tlrb_pkg::SLOT_BYTE;
                                    state_reg <= ST_PUT;
                                end
                            end
                            tlrb_pkg::KIND_TAIL:
                            begin
                                state_reg <= ST_Q_SETUP;
                            end
                            tlrb_pkg::KIND_READ:
                            begin
                                state_reg <= ST_RD_ADDR;
                            end
                            tlrb_pkg::KIND_NONE:
                            begin
                                done_reg        <= 1'b1;
                                line_count_reg  <= nl_total_reg;
                                tail_start_reg  <= '0;
                                tail_length_reg <= '0;
                                read_byte_reg   <= '0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_STAMP:
                begin
                    if (stamp_done)
                    begin
                        state_reg <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    head_reg <= head_inc;
                    if (head_inc == '0)
                    begin
                        wrapped_reg <= 1'b1;
                    end
                    if (slot_reg == tlrb_pkg::SLOT_BYTE)
                    begin
                        line_start_reg  <= (byte_reg == tlrb_pkg::CHAR_LF);
                        done_reg        <= 1'b1;
                        tail_start_reg  <= '0;
                        tail_length_reg <= '0;
                        read_byte_reg   <= '0;
                        if (byte_reg == tlrb_pkg::CHAR_LF)
                        begin
                            nl_total_reg   <= nl_total_reg + 1'b1;
                            line_count_reg <= nl_total_reg + 1'b1;
                        end
                        else
                        begin
                            line_count_reg <= nl_total_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                ST_RD_ADDR:
                begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA:
                begin
                    done_reg        <= 1'b1;
                    line_count_reg  <= nl_total_reg;
                    tail_start_reg  <= '0;
                    tail_length_reg <= '0;
                    read_byte_reg   <= rd_data;
                    state_reg       <= ST_IDLE;
                end
                ST_Q_SETUP:
                begin
                    want_reg      <= want;
                    qstart_reg    <= qstart;
                    scan_addr_reg <= qstart;
                    clipped_reg   <= (want < avail) || wrapped_reg;
                    scan_i_reg    <= '0;
                    zpos_reg      <= want;
                    nl_found_reg  <= 1'b0;
                    nl_pos_reg    <= '0;
                    state_reg     <= ST_SCAN_ADDR;
                end
                ST_SCAN_ADDR:
                begin
                    state_reg <= (scan_i_reg == want_reg) ? ST_FINISH : ST_SCAN_DATA;
                end
                ST_SCAN_DATA:
                begin
                    if (rd_data == tlrb_pkg::CHAR_NUL)
                    begin
                        // a zero byte ends the snapshot
                        zpos_reg  <= scan_i_reg;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        if ((rd_data == tlrb_pkg::CHAR_LF) && !nl_found_reg)
                        begin
                            nl_found_reg <= 1'b1;
                            nl_pos_reg   <= scan_i_reg;
                        end
                        scan_i_reg    <= scan_i_reg + 1'b1;
                        scan_addr_reg <= scan_inc;
                        state_reg     <= ST_SCAN_ADDR;
                    end
                end
                ST_FINISH:
                begin
                    done_reg        <= 1'b1;
                    line_count_reg  <= nl_total_reg;
                    tail_start_reg  <= 13'(tstart);
                    tail_length_reg <= 14'(zpos_reg - off);
                    read_byte_reg   <= '0;
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tlrb_stamp u_stamp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (stamp_start),
        .secs   (uptime_seconds),
        .done   (stamp_done),
        .digits (stamp_digits)
    );

    tlrb_ring #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (head_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done        = done_reg;
    assign line_count  = line_count_reg;
    assign tail_start  = tail_start_reg;
    assign tail_length = tail_length_reg;
    assign read_byte   = read_byte_reg;

endmodule

`default_nettype wire

// ----- design/tlrb_ring.sv -----
// ----------------------------------------------------------------------------
// tlrb_ring
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlrb_ring #(
    parameter int RING_DEPTH = 8192,
    parameter int AW         = 13
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [RING_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tlrb_stamp.sv -----
// ----------------------------------------------------------------------------
// tlrb_stamp
// Pipelined unit that splits uptime seconds into HH:MM:SS decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module tlrb_stamp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [22:0]             secs,
    output logic                         done,
    output tlrb_pkg::stamp_digits_t      digits
);

    // floor(x/60) = (x * RECIP_60) >> 29 for x below 2^23
    localparam logic [23:0] RECIP_60  = 24'd8947849;
    // floor(x/100) = (x * RECIP_100) >> 19 for x below 2^13
    localparam logic [12:0] RECIP_100 = 13'd5243;
    // floor(x/10) = (x * RECIP_10) >> 10 for x below 100
    localparam logic [6:0]  RECIP_10  = 7'd103;

    logic [4:0]  valid_reg;
    logic [22:0] secs_reg;
    logic [17:0] q1_reg;
    logic [12:0] q2_reg;
    logic [6:0]  q3_reg;
    logic [5:0]  ss_reg;
    logic [5:0]  ss_d_reg;
    logic [5:0]  mm_reg;
    logic [6:0]  hh_reg;
    tlrb_pkg::stamp_digits_t digits_reg;

    logic [46:0] prod1;
    logic [41:0] prod2;
    logic [25:0] prod3;
    logic [22:0] ss_full;
    logic [17:0] mm_full;
    logic [12:0] hh_full;

    function automatic logic [7:0] split_tens(input logic [6:0] x);
        logic [13:0] p;
        logic [3:0]  t;
        logic [6:0]  u;
        p = 14'(x) * 14'(RECIP_10);
        t = p[13:10];
        u = x - (7'(t) << 3) - (7'(t) << 1);
        split_tens = {t, u[3:0]};
    endfunction

    always_comb
    begin
        prod1   = 47'(secs_reg) * 47'(RECIP_60);
        prod2   = 42'(q1_reg) * 42'(RECIP_60);
        prod3   = 26'(q2_reg) * 26'(RECIP_100);
        ss_full = secs_reg - 23'((q1_reg << 6) - (q1_reg << 2));
        mm_full = q1_reg - 18'((18'(q2_reg) << 6) - (18'(q2_reg) << 2));
        hh_full = q2_reg - 13'((13'(q3_reg) << 6) + (13'(q3_reg) << 5)
                               + (13'(q3_reg) << 2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            secs_reg <= secs;
        end
        q1_reg   <= prod1[46:29];
        q2_reg   <= prod2[41:29];
        ss_reg   <= ss_full[5:0];
        q3_reg   <= prod3[25:19];
        mm_reg   <= mm_full[5:0];
        ss_d_reg <= ss_reg;
        hh_reg   <= hh_full[6:0];
        {digits_reg.h1, digits_reg.h0} <= split_tens(hh_reg);
        {digits_reg.m1, digits_reg.m0} <= split_tens({1'b0, mm_reg});
        {digits_reg.s1, digits_reg.s0} <= split_tens({1'b0, ss_d_reg});
    end

    assign done   = valid_reg[4];
    assign digits = digits_reg;

endmodule

`default_nettype wire

// ----- design/tlrb_checker.sv -----
// ----------------------------------------------------------------------------
// tlrb_checker
// Port-level checks on the log ring's command and result behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module tlrb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] line_count,
    input wire logic [12:0] tail_start,
    input wire logic [13:0] tail_length,
    input wire logic [7:0]  read_byte
);

    // a result closes the transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // work begins only from a start
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // a result carries either a tail answer or a read byte, never both
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((read_byte == 8'd0) || ((tail_start == 13'd0) && (tail_length == 14'd0))))
        else $error("tail and read fields both set");

    // the count moves only with a result
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!done && $past(rst_n)) |-> $stable(line_count))
        else $error("line count changed without a result");

endmodule

bind timestamped_log_ring_buffer tlrb_checker u_tlrb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .line_count  (line_count),
    .tail_start  (tail_start),
    .tail_length (tail_length),
    .read_byte   (read_byte)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the timestamped log ring with directed and random log, tail, read
// and unused transactions, checks each result, predicted or given in a table, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 8192;
    localparam int RANDOM_ITEMS = 80;
    localparam int FILL_ITEMS = 1270;
    localparam logic [7:0] CHAR_A = 8'h41;

    typedef struct {
        logic [31:0] lines;
        logic [12:0] tstart;
        logic [13:0] tlen;
        logic [7:0]  rbyte;
    } outcome_t;

    typedef struct {
        tlrb_pkg::kind_t kind;
        logic [7:0]  data;
        logic [22:0] secs;
        logic [13:0] limit;
        logic [12:0] pos;
        bit          typed;
        logic [31:0] lines;
        logic [12:0] tstart;
        logic [13:0] tlen;
        logic [7:0]  rbyte;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [22:0] uptime_seconds;
    logic [13:0] max_bytes;
    logic [12:0] position;
    logic        done;
    logic [31:0] line_count;
    logic [12:0] tail_start;
    logic [13:0] tail_length;
    logic [7:0]  read_byte;

    // Shadow of the ring and its bookkeeping
    logic [7:0]  shadow_ring [0:DEPTH-1];
    logic [12:0] head;
    bit          wrapped;
    bit          line_start;
    logic [31:0] newline_count;

    outcome_t pending_results[$];
    int       mismatches;
    bit       no_idle;

    step_t directed_steps [18] = '{
        '{tlrb_pkg::KIND_TAIL, 8'h00, 23'd0, 14'd100, 13'd0, 1'b1, 32'd0, 13'd0, 14'd0,
          8'h00},
        '{tlrb_pkg::KIND_NONE, 8'hFF, 23'h7FFFFF, 14'h3FFF, 13'h1FFF, 1'b1, 32'd0, 13'd0,
          14'd0, 8'h00},
        '{tlrb_pkg::KIND_LOG, tlrb_pkg::CHAR_CR, 23'd5, 14'd0, 13'd0, 1'b1, 32'd0, 13'd0,
          14'd0, 8'h00},
        '{tlrb_pkg::KIND_LOG, CHAR_A, 23'd359999, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_LOG, tlrb_pkg::CHAR_LF, 23'd0, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_LOG, tlrb_pkg::CHAR_LF, 23'd0, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_LOG, tlrb_pkg::CHAR_NUL, 23'd0, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_LOG, 8'hFF, 23'd4294967, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_LOG, tlrb_pkg::CHAR_LF, 23'd0, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_TAIL, 8'h00, 23'd0, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_TAIL, 8'h00, 23'd0, 14'd8192, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_TAIL, 8'h00, 23'd0, 14'h3FFF, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_TAIL, 8'h00, 23'd0, 14'd5, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_READ, 8'h00, 23'd0, 14'd0, 13'd0, 1'b1, 32'd3, 13'd0, 14'd0,
          tlrb_pkg::CHAR_OPEN},
        '{tlrb_pkg::KIND_READ, 8'h00, 23'd0, 14'd0, 13'd1, 1'b1, 32'd3, 13'd0, 14'd0,
          8'h39},
        '{tlrb_pkg::KIND_READ, 8'h00, 23'd0, 14'd0, 13'd11, 1'b1, 32'd3, 13'd0, 14'd0,
          CHAR_A},
        '{tlrb_pkg::KIND_LOG, 8'h42, 23'd1, 14'd0, 13'd0, 1'b0, 0, 0, 0, 0},
        '{tlrb_pkg::KIND_TAIL, 8'h00, 23'd0, 14'd20, 13'd0, 1'b0, 0, 0, 0, 0}
    };

    timestamped_log_ring_buffer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .data_byte      (data_byte),
        .uptime_seconds (uptime_seconds),
        .max_bytes      (max_bytes),
        .position       (position),
        .done           (done),
        .line_count     (line_count),
        .tail_start     (tail_start),
        .tail_length    (tail_length),
        .read_byte      (read_byte)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    task automatic ring_put(input logic [7:0] b);
        shadow_ring[head] = b;
        head = head + 13'd1;
        if (head == 13'd0)
            wrapped = 1'b1;
    endtask

    task automatic ring_put_stamp(input logic [22:0] secs);
        int hh, mm, ss;
        hh = (secs / 3600) % 100;
        mm = (secs / 60) % 60;
        ss = secs % 60;
        ring_put(tlrb_pkg::CHAR_OPEN);
        ring_put(8'(tlrb_pkg::CHAR_ZERO + hh / 10));
        ring_put(8'(tlrb_pkg::CHAR_ZERO + hh % 10));
        ring_put(tlrb_pkg::CHAR_COLON);
        ring_put(8'(tlrb_pkg::CHAR_ZERO + mm / 10));
        ring_put(8'(tlrb_pkg::CHAR_ZERO + mm % 10));
        ring_put(tlrb_pkg::CHAR_COLON);
        ring_put(8'(tlrb_pkg::CHAR_ZERO + ss / 10));
        ring_put(8'(tlrb_pkg::CHAR_ZERO + ss % 10));
        ring_put(tlrb_pkg::CHAR_CLOSE);
        ring_put(tlrb_pkg::CHAR_SPACE);
    endtask

    // Advance the shadow state by one transaction and return its result
    task automatic log_ring_predict(input tlrb_pkg::kind_t k, input logic [7:0] d,
                                    input logic [22:0] secs, input logic [13:0] limit,
                                    input logic [12:0] pos, output outcome_t res);
        int avail, want, first, zpos, off, lim;
        res = '{newline_count, 13'd0, 14'd0, 8'h00};
        case (k)
            tlrb_pkg::KIND_LOG:
            begin
                if (d != tlrb_pkg::CHAR_CR)
                begin
                    if (line_start && d != tlrb_pkg::CHAR_LF)
                    begin
                        ring_put_stamp(secs);
                        line_start = 1'b0;
                    end
                    if (d == tlrb_pkg::CHAR_LF)
                    begin
                        line_start = 1'b1;
                        newline_count = newline_count + 32'd1;
                    end
                    ring_put(d);
                end
            end
            tlrb_pkg::KIND_TAIL:
            begin
                avail = wrapped ? DEPTH : int'(head);
                lim = (limit > DEPTH) ? DEPTH : int'(limit);
                want = (lim < avail) ? lim : avail;
                first = (int'(head) + DEPTH - want) % DEPTH;
                zpos = want;
                for (int i = 0; i < want; i++)
                begin
                    if (shadow_ring[(first + i) % DEPTH] == tlrb_pkg::CHAR_NUL)
                    begin
                        zpos = i;
                        break;
                    end
                end
                off = 0;
                // skip the partial first line of a clipped snapshot
                if (want < avail || wrapped)
                begin
                    for (int i = 0; i < zpos; i++)
                    begin
                        if (shadow_ring[(first + i) % DEPTH] == tlrb_pkg::CHAR_LF)
                        begin
                            if (i + 1 < zpos)
                                off = i + 1;
                            break;
                        end
                    end
                end
                res.tstart = 13'((first + off) % DEPTH);
                res.tlen = 14'(zpos - off);
            end
            tlrb_pkg::KIND_READ:
                res.rbyte = shadow_ring[pos];
            default: ;
        endcase
        res.lines = newline_count;
    endtask

    // Offer one transaction, hold it until accepted, then record its result
    task automatic issue(input tlrb_pkg::kind_t k, input logic [7:0] d,
                         input logic [22:0] secs,
                         input logic [13:0] limit, input logic [12:0] pos,
                         input bit typed, input outcome_t typed_res);
        outcome_t res;
        if (!no_idle && $urandom_range(0, 99) < 34)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        data_byte <= d;
        uptime_seconds <= secs;
        max_bytes <= limit;
        position <= pos;
        do
            @(posedge clk);
        while (busy);
        log_ring_predict(k, d, secs, limit, pos, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_item();
        tlrb_pkg::kind_t k;
        logic [7:0]  d;
        logic [13:0] limit;
        logic [12:0] pos;
        int          r;
        outcome_t    none;
        none = '{0, 0, 0, 0};
        r = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        limit = 14'($urandom_range(0, 64));
        pos = 13'($urandom_range(0, DEPTH - 1));
        if (r < 70)
        begin
            k = tlrb_pkg::KIND_LOG;
            r = $urandom_range(0, 99);
            if (r < 40)
                d = tlrb_pkg::CHAR_LF;
            else if (r < 45)
                d = tlrb_pkg::CHAR_CR;
            else if (r < 48)
                d = tlrb_pkg::CHAR_NUL;
        end
        else if (r < 84)
        begin
            k = tlrb_pkg::KIND_TAIL;
            r = $urandom_range(0, 99);
            if (r < 3)
                limit = 14'($urandom_range(0, 16383));
            else if (r < 10)
                limit = 14'($urandom_range(0, 1023));
        end
        else if (r < 96 && (wrapped || head != 13'd0))
        begin
            k = tlrb_pkg::KIND_READ;
            // never read an entry that has not been written
            if (!wrapped)
                pos = 13'($urandom_range(0, int'(head) - 1));
        end
        else
            k = tlrb_pkg::KIND_NONE;
        issue(k, d, 23'($urandom_range(0, 4294967)), limit, pos, 1'b0, none);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected done", 32'd1, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (line_count !== want.lines)
                    report("line_count", line_count, want.lines);
                if (tail_start !== want.tstart)
                    report("tail_start", 32'(tail_start), 32'(want.tstart));
                if (tail_length !== want.tlen)
                    report("tail_length", 32'(tail_length), 32'(want.tlen));
                if (read_byte !== want.rbyte)
                    report("read_byte", 32'(read_byte), 32'(want.rbyte));
            end
        end
    end

    initial
    begin
        outcome_t none;
        none = '{0, 0, 0, 0};
        mismatches = 0;
        no_idle = 1'b0;
        head = 13'd0;
        wrapped = 1'b0;
        line_start = 1'b1;
        newline_count = 32'd0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = tlrb_pkg::KIND_NONE;
        data_byte = 8'h00;
        uptime_seconds = 23'd0;
        max_bytes = 14'd0;
        position = 13'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            issue(directed_steps[i].kind, directed_steps[i].data, directed_steps[i].secs,
                  directed_steps[i].limit, directed_steps[i].pos, directed_steps[i].typed,
                  '{directed_steps[i].lines, directed_steps[i].tstart,
                    directed_steps[i].tlen, directed_steps[i].rbyte});

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            random_item();
        wait_drained();

        // short stamped lines to push the head round the ring
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            no_idle = (i >= 200 && i < 500);
            issue(tlrb_pkg::KIND_LOG,
                  (i % 2 == 1) ? tlrb_pkg::CHAR_LF : 8'($urandom_range(33, 126)),
                  23'($urandom_range(0, 4294967)), 14'd0, 13'd0, 1'b0, none);
        end
        no_idle = 1'b0;

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            random_item();

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
